### sv/cc_pkg.sv
// ----------------------------------------------------------------------------
// cc_pkg
// Shared types, constants and helper functions of the ChaCha20 stream core.
// ----------------------------------------------------------------------------
package cc_pkg;

	localparam logic [31:0] CC_SIGMA0 = 32'h6170_7865;
	localparam logic [31:0] CC_SIGMA1 = 32'h3320_646e;
	localparam logic [31:0] CC_SIGMA2 = 32'h7962_2d32;
	localparam logic [31:0] CC_SIGMA3 = 32'h6b20_6574;

	localparam int CC_DOUBLE_ROUNDS = 10;
	localparam logic [4:0] CC_LAST_HALF = 5'(2 * CC_DOUBLE_ROUNDS - 1);

	localparam int CC_CFG_IDX_W = 3;
	localparam logic [CC_CFG_IDX_W-1:0] CC_REG_KEY0      = 3'd0;
	localparam logic [CC_CFG_IDX_W-1:0] CC_REG_KEY1      = 3'd1;
	localparam logic [CC_CFG_IDX_W-1:0] CC_REG_KEY2      = 3'd2;
	localparam logic [CC_CFG_IDX_W-1:0] CC_REG_KEY3      = 3'd3;
	localparam logic [CC_CFG_IDX_W-1:0] CC_REG_NONCE_LO  = 3'd4;
	localparam logic [CC_CFG_IDX_W-1:0] CC_REG_NONCE_HI  = 3'd5;
	localparam logic [CC_CFG_IDX_W-1:0] CC_REG_START_CTR = 3'd6;

	localparam logic [1:0] CC_STEP_AD16 = 2'd0;
	localparam logic [1:0] CC_STEP_CB12 = 2'd1;
	localparam logic [1:0] CC_STEP_AD8  = 2'd2;
	localparam logic [1:0] CC_STEP_CB7  = 2'd3;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} cc_in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
	} cc_out_t;

	// item as classified by the front end
	typedef struct packed {
		cc_in_t     item;
		logic [5:0] pos;
		logic       new_msg;
	} cc_tag_t;

	typedef struct packed {
		logic        start;
		logic [31:0] counter;
	} cc_gen_req_t;

	typedef logic [15:0][31:0] cc_block_t;

	typedef enum logic [1:0] {
		CR_IDLE,
		CR_ROUND,
		CR_ADD
	} cc_core_state_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_GEN,
		BK_EMIT
	} cc_back_state_t;

	function automatic cc_block_t cc_init_words(input logic [255:0] key,
			input logic [95:0] nonce, input logic [31:0] counter);
		cc_block_t w;
		w[0]  = CC_SIGMA0;
		w[1]  = CC_SIGMA1;
		w[2]  = CC_SIGMA2;
		w[3]  = CC_SIGMA3;
		for (int k = 0; k < 8; k++) begin
			w[4+k] = key[32*k +: 32];
		end
		w[12] = counter;
		w[13] = nonce[31:0];
		w[14] = nonce[63:32];
		w[15] = nonce[95:64];
		return w;
	endfunction

	// word index of a quarter-round operand: role 0..3 is a, b, c, d
	function automatic logic [3:0] cc_widx(input logic [1:0] lane,
			input logic [1:0] role, input logic diag);
		logic [1:0] col;
		col = lane + (diag ? role : 2'd0);
		return {role, col};
	endfunction

endpackage

### sv/cc_front.sv
// ----------------------------------------------------------------------------
// cc_front
// Input side: accepts bytes, tags each with its block position and message
// start, and holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module cc_front
	import cc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	output logic    full,
	input  cc_in_t  in_item,
	output logic    head_valid,
	output cc_tag_t head,
	input  logic    deq
);

	logic       active_q;
	logic [5:0] pos_q;
	cc_tag_t    mem_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] cnt_q;
	logic       accept;
	cc_tag_t    tag;

	assign full       = (cnt_q == 2'd2);
	assign accept     = push && !full;
	assign head_valid = (cnt_q != 2'd0);
	assign head       = mem_q[rptr_q];

	always_comb begin
		tag.item    = in_item;
		tag.pos     = active_q ? pos_q : 6'd0;
		tag.new_msg = !active_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			pos_q    <= 6'd0;
			wptr_q   <= 1'b0;
			rptr_q   <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (accept) begin
				pos_q    <= tag.pos + 6'd1;
				active_q <= !in_item.last_byte;
				wptr_q   <= !wptr_q;
			end
			if (deq) begin
				rptr_q <= !rptr_q;
			end
			case ({accept, deq})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mem_q[wptr_q] <= tag;
		end
	end

endmodule

### sv/cc_core.sv
// ----------------------------------------------------------------------------
// cc_core
// Keystream block generator: four quarter-round lanes, one add-xor-rotate
// step per lane per cycle, columns and diagonals alternating, then add-back.
// ----------------------------------------------------------------------------
module cc_core
	import cc_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic [255:0] key,
	input  logic [95:0]  nonce,
	input  cc_gen_req_t  req,
	output logic         done,
	output cc_block_t    words
);

	cc_core_state_t state_q;
	cc_core_state_t state_d;
	logic [4:0]     half_q;
	logic [1:0]     step_q;
	logic [31:0]    ctr_q;
	logic [31:0]    w_q [16];
	logic [31:0]    w_d [16];
	cc_block_t      init_words;
	logic           load;
	logic           step_en;
	logic           add_en;

	assign init_words = cc_init_words(key, nonce, load ? req.counter : ctr_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			CR_IDLE: begin
				if (req.start) state_d = CR_ROUND;
			end
			CR_ROUND: begin
				if (half_q == CC_LAST_HALF && step_q == CC_STEP_CB7) state_d = CR_ADD;
			end
			CR_ADD: state_d = CR_IDLE;
			default: state_d = CR_IDLE;
		endcase
	end

	always_comb begin
		load    = 1'b0;
		step_en = 1'b0;
		add_en  = 1'b0;
		case (state_q)
			CR_IDLE:  load    = req.start;
			CR_ROUND: step_en = 1'b1;
			CR_ADD:   add_en  = 1'b1;
			default:  load    = 1'b0;
		endcase
	end

	assign done = add_en;

	always_comb begin
		logic [3:0]  ia, ib, ic, id;
		logic [31:0] s, t;
		for (int i = 0; i < 16; i++) begin
			w_d[i] = add_en ? w_q[i] + init_words[i] : w_q[i];
		end
		for (int l = 0; l < 4; l++) begin
			ia = cc_widx(2'(l), 2'd0, half_q[0]);
			ib = cc_widx(2'(l), 2'd1, half_q[0]);
			ic = cc_widx(2'(l), 2'd2, half_q[0]);
			id = cc_widx(2'(l), 2'd3, half_q[0]);
			if (step_q[0] == 1'b0) begin
				s = w_q[ia] + w_q[ib];
				t = w_q[id] ^ s;
			end else begin
				s = w_q[ic] + w_q[id];
				t = w_q[ib] ^ s;
			end
			if (step_en) begin
				case (step_q)
					CC_STEP_AD16: begin
						w_d[ia] = s;
						w_d[id] = {t[15:0], t[31:16]};
					end
					CC_STEP_CB12: begin
						w_d[ic] = s;
						w_d[ib] = {t[19:0], t[31:20]};
					end
					CC_STEP_AD8: begin
						w_d[ia] = s;
						w_d[id] = {t[23:0], t[31:24]};
					end
					CC_STEP_CB7: begin
						w_d[ic] = s;
						w_d[ib] = {t[24:0], t[31:25]};
					end
					default: w_d[ia] = w_q[ia];
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CR_IDLE;
			half_q  <= 5'd0;
			step_q  <= 2'd0;
		end else begin
			state_q <= state_d;
			if (load) begin
				half_q <= 5'd0;
				step_q <= 2'd0;
			end else if (step_en) begin
				step_q <= step_q + 2'd1;
				if (step_q == CC_STEP_CB7) half_q <= half_q + 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ctr_q <= req.counter;
			for (int i = 0; i < 16; i++) w_q[i] <= init_words[i];
		end else if (step_en || add_en) begin
			for (int i = 0; i < 16; i++) w_q[i] <= w_d[i];
		end
	end

	always_comb begin
		for (int i = 0; i < 16; i++) words[i] = w_q[i];
	end

endmodule

### sv/cc_back.sv
// ----------------------------------------------------------------------------
// cc_back
// Execution side: takes tagged bytes, has a block made at each block start,
// XORs the keystream byte and holds the result in a one-entry output slot.
// ----------------------------------------------------------------------------
module cc_back
	import cc_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic [255:0] key,
	input  logic [95:0]  nonce,
	input  logic [31:0]  start_counter,
	input  logic         head_valid,
	input  cc_tag_t      head,
	output logic         deq,
	output logic         empty,
	input  logic         pop,
	output cc_out_t      out_item
);

	cc_back_state_t state_q;
	cc_back_state_t state_d;
	logic [31:0]    ctr_q;
	cc_gen_req_t    req;
	logic           gen_done;
	cc_block_t      words;
	logic           out_valid_q;
	cc_out_t        out_q;
	logic           can_out;
	logic           block_start;
	logic [31:0]    ks_word;
	logic [7:0]     ks_byte;

	cc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.key    (key),
		.nonce  (nonce),
		.req    (req),
		.done   (gen_done),
		.words  (words)
	);

	assign can_out     = !out_valid_q || pop;
	assign block_start = head_valid && (head.pos == 6'd0);

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (block_start) state_d = BK_GEN;
			end
			BK_GEN: begin
				if (gen_done) state_d = BK_EMIT;
			end
			BK_EMIT: begin
				if (deq) state_d = BK_IDLE;
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		req.start   = 1'b0;
		req.counter = head.new_msg ? start_counter : ctr_q;
		deq         = 1'b0;
		case (state_q)
			BK_IDLE: begin
				req.start = block_start;
				deq       = head_valid && !block_start && can_out;
			end
			BK_EMIT: deq = head_valid && can_out;
			default: deq = 1'b0;
		endcase
	end

	assign ks_word = words[head.pos[5:2]];
	assign ks_byte = ks_word[{head.pos[1:0], 3'b000} +: 8];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			ctr_q       <= 32'd0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// counter wraps modulo 2^32
			if (req.start) ctr_q <= req.counter + 32'd1;
			if (deq) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (deq) begin
			out_q.out_byte <= head.item.data_byte ^ ks_byte;
			out_q.out_last <= head.item.last_byte;
		end
	end

	assign empty    = !out_valid_q;
	assign out_item = out_q;

endmodule

### sv/chacha20_stream_xor_core.sv
// ----------------------------------------------------------------------------
// chacha20_stream_xor_core
// ChaCha20 stream XOR with 256-bit key, 96-bit nonce and 32-bit block counter.
// ----------------------------------------------------------------------------
// Each pushed byte comes out XORed with the next keystream byte, one result
// per byte, in order. A keystream block is made when a byte falls at position
// zero of a 64-byte block: a start step that loads the state, quarter-round
// steps (four lanes, one add-xor-rotate step each per cycle) and an add-back
// step. That byte waits for the block; every other byte of the block uses the
// stored keystream and needs no new block. A byte with last set
// ends the message; the next one restarts at the configured start counter.
// Key and nonce registers are read when a block is made, start_counter when a
// message starts; write them only while no transaction is in flight.
module chacha20_stream_xor_core
	import cc_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	output logic                    full,
	input  cc_in_t                  in_item,
	output logic                    empty,
	input  logic                    pop,
	output cc_out_t                 out_item,
	input  logic                    cfg_we,
	input  logic [CC_CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]             cfg_data
);

	logic [63:0] key0_q;
	logic [63:0] key1_q;
	logic [63:0] key2_q;
	logic [63:0] key3_q;
	logic [63:0] nonce_lo_q;
	logic [31:0] nonce_hi_q;
	logic [31:0] start_ctr_q;
	logic        head_valid;
	cc_tag_t     head;
	logic        deq;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key0_q      <= 64'd0;
			key1_q      <= 64'd0;
			key2_q      <= 64'd0;
			key3_q      <= 64'd0;
			nonce_lo_q  <= 64'd0;
			nonce_hi_q  <= 32'd0;
			start_ctr_q <= 32'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				CC_REG_KEY0:      key0_q      <= cfg_data;
				CC_REG_KEY1:      key1_q      <= cfg_data;
				CC_REG_KEY2:      key2_q      <= cfg_data;
				CC_REG_KEY3:      key3_q      <= cfg_data;
				CC_REG_NONCE_LO:  nonce_lo_q  <= cfg_data;
				CC_REG_NONCE_HI:  nonce_hi_q  <= cfg_data[31:0];
				CC_REG_START_CTR: start_ctr_q <= cfg_data[31:0];
				default:          start_ctr_q <= start_ctr_q;
			endcase
		end
	end

	cc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.in_item    (in_item),
		.head_valid (head_valid),
		.head       (head),
		.deq        (deq)
	);

	cc_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.key           ({key3_q, key2_q, key1_q, key0_q}),
		.nonce         ({nonce_hi_q, nonce_lo_q}),
		.start_counter (start_ctr_q),
		.head_valid    (head_valid),
		.head          (head),
		.deq           (deq),
		.empty         (empty),
		.pop           (pop),
		.out_item      (out_item)
	);

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ChaCha20 stream XOR core.
// ----------------------------------------------------------------------------
// Bytes go in through the push/full side and come back through empty/pop. Each
// accepted byte is run through a local ChaCha20 keystream generator to form the
// expected output byte and last flag. Output transactions are checked in order.
// A short directed pass covers single-byte messages, field extremes and a key
// change part-way through a message. Four random passes follow, each with its
// own key, nonce and start counter, including all-zero, all-ones and a start
// counter that wraps. Sender and receiver idle at varying rates. One long
// receiver hold makes the core back up and stall its input.
// ----------------------------------------------------------------------------
module tb;
	import cc_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int PHASE_BYTES = 200;
	localparam int SETTLE_CYCLES = 100;

	class cc_keystream_board;
		logic [255:0] key;
		logic [95:0]  nonce;
		logic [31:0]  start_ctr;
		logic [31:0]  blk_ctr;
		logic [5:0]   pos;
		bit           in_msg;
		logic [31:0]  ks [16];
		logic [31:0]  mix [16];
		cc_out_t      due_q [$];
		int           errors;
		int           bytes_seen;
		int           msgs_done;
		int           blocks_made;
		int           wraps;

		function new();
			key = '0;
			nonce = '0;
			start_ctr = '0;
			blk_ctr = '0;
			pos = '0;
			in_msg = 0;
			errors = 0;
			bytes_seen = 0;
			msgs_done = 0;
			blocks_made = 0;
			wraps = 0;
		endfunction

		function void set_reg(logic [CC_CFG_IDX_W-1:0] idx, logic [63:0] val);
			case (idx)
				CC_REG_KEY0:      key[63:0] = val;
				CC_REG_KEY1:      key[127:64] = val;
				CC_REG_KEY2:      key[191:128] = val;
				CC_REG_KEY3:      key[255:192] = val;
				CC_REG_NONCE_LO:  nonce[63:0] = val;
				CC_REG_NONCE_HI:  nonce[95:64] = val[31:0];
				CC_REG_START_CTR: start_ctr = val[31:0];
				default: ;
			endcase
		endfunction

		function logic [31:0] rotl(logic [31:0] v, int n);
			return (v << n) | (v >> (32 - n));
		endfunction

		function void quarter(int a, int b, int c, int d);
			mix[a] = mix[a] + mix[b];
			mix[d] = rotl(mix[d] ^ mix[a], 16);
			mix[c] = mix[c] + mix[d];
			mix[b] = rotl(mix[b] ^ mix[c], 12);
			mix[a] = mix[a] + mix[b];
			mix[d] = rotl(mix[d] ^ mix[a], 8);
			mix[c] = mix[c] + mix[d];
			mix[b] = rotl(mix[b] ^ mix[c], 7);
		endfunction

		// key and nonce are taken as they stand when the block is made
		function void gen_block();
			logic [31:0] init_w [16];
			init_w[0] = CC_SIGMA0;
			init_w[1] = CC_SIGMA1;
			init_w[2] = CC_SIGMA2;
			init_w[3] = CC_SIGMA3;
			for (int k = 0; k < 8; k++)
				init_w[4+k] = key[32*k +: 32];
			init_w[12] = blk_ctr;
			init_w[13] = nonce[31:0];
			init_w[14] = nonce[63:32];
			init_w[15] = nonce[95:64];
			mix = init_w;
			for (int r = 0; r < CC_DOUBLE_ROUNDS; r++) begin
				quarter(0, 4, 8, 12);
				quarter(1, 5, 9, 13);
				quarter(2, 6, 10, 14);
				quarter(3, 7, 11, 15);
				quarter(0, 5, 10, 15);
				quarter(1, 6, 11, 12);
				quarter(2, 7, 8, 13);
				quarter(3, 4, 9, 14);
			end
			for (int i = 0; i < 16; i++)
				ks[i] = mix[i] + init_w[i];
			blocks_made++;
		endfunction

		function void note_byte(cc_in_t it);
			logic [31:0] w;
			cc_out_t     o;
			if (!in_msg) begin
				blk_ctr = start_ctr;
				pos = '0;
				in_msg = 1;
			end
			if (pos == 0) begin
				gen_block();
				if (blk_ctr == 32'hFFFF_FFFF)
					wraps++;
				blk_ctr = blk_ctr + 32'd1;
			end
			w = ks[pos[5:2]];
			o.out_byte = it.data_byte ^ w[8*pos[1:0] +: 8];
			o.out_last = it.last_byte;
			due_q.push_back(o);
			pos = pos + 6'd1;
			bytes_seen++;
			if (it.last_byte) begin
				in_msg = 0;
				msgs_done++;
			end
		endfunction

		function void check_byte(cc_out_t got);
			cc_out_t want;
			if (due_q.size() == 0) begin
				$display("%0t: output transaction with none pending: byte %h last %b",
					$time, got.out_byte, got.out_last);
				errors++;
				return;
			end
			want = due_q.pop_front();
			if (got.out_byte !== want.out_byte) begin
				$display("%0t: out_byte mismatch: expected %h, actual %h",
					$time, want.out_byte, got.out_byte);
				errors++;
			end
			if (got.out_last !== want.out_last) begin
				$display("%0t: out_last mismatch: expected %b, actual %b",
					$time, want.out_last, got.out_last);
				errors++;
			end
		endfunction
	endclass

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    push = 1'b0;
	logic                    full;
	cc_in_t                  in_item = '0;
	logic                    empty;
	logic                    pop = 1'b0;
	cc_out_t                 out_item;
	logic                    cfg_we = 1'b0;
	logic [CC_CFG_IDX_W-1:0] cfg_index = '0;
	logic [63:0]             cfg_data = '0;

	cc_keystream_board sb = new();
	int cycles = 0;
	int gap_pct = 0;
	int stall_pct = 0;
	int hold_left = 0;
	int full_stalls = 0;
	int loads = 0;

	chacha20_stream_xor_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.in_item   (in_item),
		.empty     (empty),
		.pop       (pop),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t: timed out with %0d transactions pending", $time, sb.due_q.size());
			$display("FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full)
				sb.note_byte(in_item);
			if (push && full)
				full_stalls++;
			if (pop && !empty)
				sb.check_byte(out_item);
		end
	end

	// receiver: a pending hold overrides the random stall rate
	initial begin
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				pop <= 1'b0;
				hold_left--;
			end else begin
				pop <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	task automatic send_byte(logic [7:0] data, logic last);
		if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		push <= 1'b1;
		in_item <= '{data_byte: data, last_byte: last};
		do @(posedge clk); while (full);
	endtask

	task automatic write_reg(logic [CC_CFG_IDX_W-1:0] idx, logic [63:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		sb.set_reg(idx, val);
	endtask

	task automatic load_config(logic [255:0] key, logic [95:0] nonce, logic [31:0] ctr);
		write_reg(CC_REG_KEY0, key[63:0]);
		write_reg(CC_REG_KEY1, key[127:64]);
		write_reg(CC_REG_KEY2, key[191:128]);
		write_reg(CC_REG_KEY3, key[255:192]);
		write_reg(CC_REG_NONCE_LO, nonce[63:0]);
		write_reg(CC_REG_NONCE_HI, {32'd0, nonce[95:64]});
		write_reg(CC_REG_START_CTR, {32'd0, ctr});
		cfg_we <= 1'b0;
		loads++;
	endtask

	// drop push, let every pending transaction come back, then settle
	task automatic drain();
		push <= 1'b0;
		while (sb.due_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// whole messages of mixed length; the last one may be cut short
	task automatic run_messages(int n_bytes);
		int sent;
		int len;
		int pick;
		sent = 0;
		while (sent < n_bytes) begin
			pick = $urandom_range(99);
			if (pick < 30)
				len = $urandom_range(1, 4);
			else if (pick < 80)
				len = $urandom_range(5, 70);
			else
				len = $urandom_range(60, 140);
			for (int i = 0; i < len && sent < n_bytes; i++) begin
				send_byte(8'($urandom), i == len - 1);
				sent++;
			end
		end
	endtask

	function automatic logic [255:0] rand_key();
		return {$urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom, $urandom};
	endfunction

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// registers still at reset: all-zero key, nonce and counter
		send_byte(8'h00, 1'b1);
		drain();

		load_config({256{1'b1}}, {96{1'b1}}, 32'hFFFF_FFFF);
		send_byte(8'hFF, 1'b1);
		send_byte(8'h00, 1'b1);
		send_byte(8'hA5, 1'b0);
		send_byte(8'h5A, 1'b0);
		send_byte(8'hFF, 1'b0);
		drain();

		// change everything part-way through a message
		load_config({64{4'h5}}, {24{4'hA}}, 32'h8000_0000);
		send_byte(8'h3C, 1'b0);
		send_byte(8'hC3, 1'b1);
		send_byte(8'h80, 1'b1);
		send_byte(8'h01, 1'b1);
		drain();

		// no idling; long receiver hold backs the core up
		load_config(rand_key(), {$urandom, $urandom, $urandom}, $urandom);
		gap_pct = 0;
		stall_pct = 0;
		hold_left = 1500;
		run_messages(PHASE_BYTES);
		drain();

		// sender idles; counter wraps on any message past one block
		load_config('0, '0, 32'hFFFF_FFFF);
		gap_pct = 53;
		stall_pct = 0;
		run_messages(PHASE_BYTES);
		drain();

		load_config({256{1'b1}}, {96{1'b1}}, 32'h0000_0000);
		gap_pct = 0;
		stall_pct = 53;
		run_messages(PHASE_BYTES);
		drain();

		load_config(rand_key(), {$urandom, $urandom, $urandom}, 32'hFFFF_FFFE);
		gap_pct = 15;
		stall_pct = 15;
		run_messages(PHASE_BYTES);
		drain();

		$display("Covered %0d bytes in %0d complete messages, %0d keystream blocks, %0d counter wraps.",
			sb.bytes_seen, sb.msgs_done, sb.blocks_made, sb.wraps);
		$display("Register loads: %0d; input held off by full on %0d cycles; %0d mismatches.",
			loads, full_stalls, sb.errors);
		if (sb.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

### chacha20_stream_xor_core.f
sv/cc_pkg.sv
sv/cc_front.sv
sv/cc_core.sv
sv/cc_back.sv
sv/chacha20_stream_xor_core.sv
tb/tb.sv
